>>> rtl/spp_pkg.sv
// Package for the stripped partition product block.
// Holds request codes, queue command types and shared constants; no dependencies.
package spp_pkg;

   // request codes on the input channel
   typedef enum logic [2:0] {
      REQ_LEFT_ID     = 3'd0,
      REQ_CLOSE_LEFT  = 3'd1,
      REQ_RIGHT_ID    = 3'd2,
      REQ_CLOSE_GROUP = 3'd3,
      REQ_END_LIST    = 3'd4,
      REQ_CLEAR       = 3'd5
   } req_code_type;

   // commands passed from front to back
   typedef enum logic [1:0] {
      CMD_ID    = 2'd0,
      CMD_CLOSE = 2'd1,
      CMD_END   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_kind_type;

   localparam int CLS_W = 17;
   localparam int TID_W = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam logic [CLS_W-1:0] CLASS_LIMIT = 17'd131070;
   localparam logic [CLS_W-1:0] SETS_LIMIT  = 17'd65536;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [CLS_W-1:0]   cls;
      logic [TID_W-1:0]   tid;
   } cmd_type;

   typedef struct packed {
      logic [CLS_W-1:0] cls;
      logic [TID_W-1:0] tid;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EMIT = 1'b1
   } back_state_type;

endpackage

>>> rtl/spp_if.sv
// Channel interfaces for the stripped partition product block.
// Request and result channels with valid/ready handshake; no dependencies.
interface spp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [15:0] tid;
   modport source(output valid, req_type, tid, input ready);
   modport sink(input valid, req_type, tid, output ready);
endinterface

interface spp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_tid;
   logic        class_end;
   logic        last;
   logic [16:0] set_count;
   logic        overflow;
   modport source(output valid, out_tid, class_end, last, set_count, overflow, input ready);
   modport sink(input valid, out_tid, class_end, last, set_count, overflow, output ready);
endinterface

>>> rtl/stripped_partition_product.sv
// Top level of the stripped partition product block.
// Depends on spp_pkg, spp_if, spp_front, spp_queue and spp_back.
//
// Usage: left ids and left class closes load the id-to-class map; right ids
// are looked up and kept, sorted by class, for the current group. A group
// close or end of list sends the kept ids out on the result channel, one
// item per id, lowest class first, arrival order within a class.
// Requests enter on req_if (valid/ready), results leave on rsp_if.
// Throughput: the front takes no new request while one is still pending (a map
// access, then the read data is classified). A group close then emits one
// result per cycle while the receiver keeps ready high; the first result of
// a close passes the pending stage, the command queue and the back to the result register.
// Reset and clear both start a sweep of the map, one entry per cycle,
// over all ID_SPACE entries, during which no request is taken.
// When the receiver stalls, the result register holds, the back stops
// emitting, and once the command queue fills the front drops ready.
module stripped_partition_product #(
   parameter int ID_SPACE    = 65536,
   parameter int GROUP_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   spp_req_if.sink    req_if,
   spp_rsp_if.source  rsp_if
);
   import spp_pkg::*;

   logic          push;
   cmd_type       push_cmd;
   logic          q_pop;
   cmd_type       q_cmd;
   q_status_type  q_status;

   spp_front #(.ID_SPACE(ID_SPACE)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   spp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (q_cmd),
      .status   (q_status)
   );

   spp_back #(.GROUP_DEPTH(GROUP_DEPTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop),
      .rsp_if   (rsp_if)
   );

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid after reset");

   // never take a request into a full queue
   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> !q_status.full)
      else $error("request accepted with queue full");

   // pop only a filled queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

endmodule

>>> rtl/spp_queue.sv
// Short command queue between front and back of the partition product.
// Depends on spp_pkg.
module spp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  spp_pkg::cmd_type push_cmd,
   input  logic             pop,
   output spp_pkg::cmd_type pop_cmd,
   output spp_pkg::q_status_type status
);
   import spp_pkg::*;

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold command entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

>>> rtl/spp_front.sv
// Front of the partition product: accepts requests, keeps the id-to-class map.
// Depends on spp_pkg and spp_if; pushes commands into spp_queue.
module spp_front #(
   parameter int ID_SPACE = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   spp_req_if.sink                req_if,
   input  spp_pkg::q_status_type  q_status,
   output logic                   push,
   output spp_pkg::cmd_type       push_cmd
);
   import spp_pkg::*;

   localparam int AW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;

   logic [CLS_W-1:0]  map_mem [ID_SPACE];
   logic [CLS_W-1:0]  rd_data_ff;

   logic              sweep_ff, sweep_in;
   logic [AW-1:0]     sweep_cnt_ff, sweep_cnt_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_code_ff;
   logic [TID_W-1:0]  s1_tid_ff;
   logic              s1_range_ff;
   logic [CLS_W-1:0]  left_count_ff, left_count_in;

   logic              acc;
   logic              in_range;
   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [CLS_W-1:0]  mem_wdata;

   assign req_if.ready = !sweep_ff && !s1_valid_ff && !q_status.full;
   assign acc          = req_if.valid && req_if.ready;
   assign in_range     = (32'(req_if.tid) < 32'(ID_SPACE));

   // map port: sweep clears, left ids write, right ids read
   always_comb begin
      mem_we    = sweep_ff || (acc && req_if.req_type == REQ_LEFT_ID && in_range);
      mem_addr  = sweep_ff ? sweep_cnt_ff : AW'(req_if.tid);
      mem_wdata = sweep_ff ? '0 : left_count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= map_mem[mem_addr];
   end

   // sweep, class counter and pending stage
   always_comb begin
      sweep_in      = sweep_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      left_count_in = left_count_ff;
      s1_valid_in   = acc;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         if (sweep_cnt_ff == AW'(ID_SPACE - 1)) begin
            sweep_in = 1'b0;
         end
      end
      if (acc && req_if.req_type == REQ_CLOSE_LEFT && left_count_ff < CLASS_LIMIT) begin
         left_count_in = left_count_ff + 1'b1;
      end
      if (acc && req_if.req_type == REQ_CLEAR) begin
         sweep_in      = 1'b1;
         sweep_cnt_in  = '0;
         left_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_cnt_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         left_count_ff <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         left_count_ff <= left_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_code_ff  <= req_if.req_type;
         s1_tid_ff   <= req_if.tid;
         s1_range_ff <= in_range;
      end
   end

   // classify the pending item into a back command
   always_comb begin
      push          = 1'b0;
      push_cmd.kind = CMD_ID;
      push_cmd.cls  = rd_data_ff;
      push_cmd.tid  = s1_tid_ff;
      if (s1_valid_ff) begin
         case (s1_code_ff)
            REQ_RIGHT_ID: begin
               push = s1_range_ff && (rd_data_ff != '0);
            end
            REQ_CLOSE_GROUP: begin
               push          = 1'b1;
               push_cmd.kind = CMD_CLOSE;
            end
            REQ_END_LIST: begin
               push          = 1'b1;
               push_cmd.kind = CMD_END;
            end
            REQ_CLEAR: begin
               push          = 1'b1;
               push_cmd.kind = CMD_CLEAR;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

endmodule

>>> rtl/spp_back.sv
// Back of the partition product: sorted group buffer and result emission.
// Depends on spp_pkg and spp_if; pops commands from spp_queue.
module spp_back #(
   parameter int GROUP_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spp_pkg::q_status_type  q_status,
   input  spp_pkg::cmd_type       q_cmd,
   output logic                   q_pop,
   spp_rsp_if.source              rsp_if
);
   import spp_pkg::*;

   localparam int FW = $clog2(GROUP_DEPTH + 1);

   back_state_type    state_ff, state_in;
   entry_type         ent_ff [GROUP_DEPTH];
   entry_type         ins    [GROUP_DEPTH];
   entry_type         shl    [GROUP_DEPTH];
   logic [GROUP_DEPTH-1:0] mv;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [CLS_W-1:0]  sets_ff, sets_in;
   logic [CLS_W-1:0]  sets_inc;
   logic              ovf_ff, ovf_in;
   logic              end_ff, end_in;
   logic              first_ff, first_in;
   logic [CLS_W-1:0]  prev_cls_ff;

   logic              rsp_valid_ff;
   logic [TID_W-1:0]  rsp_tid_ff;
   logic              rsp_end_ff;
   logic              rsp_last_ff;
   logic [CLS_W-1:0]  rsp_sets_ff;
   logic              rsp_ovf_ff;

   logic              step;
   logic              do_insert;
   logic              is_last;
   logic              cls_start;
   logic              cls_end;
   logic              close_cmd;

   // sorted insert and shift-out, one cell per buffer entry
   for (genvar i = 0; i < GROUP_DEPTH; i++) begin : g_cell
      assign mv[i] = (FW'(i) < fill_ff) && (ent_ff[i].cls > q_cmd.cls);
      if (i == 0) begin : g_head
         assign ins[i] = (mv[i] || fill_ff == '0) ? entry_type'({q_cmd.cls, q_cmd.tid})
                                                  : ent_ff[i];
      end else begin : g_body
         assign ins[i] = mv[i-1] ? ent_ff[i-1] :
                         (mv[i] || FW'(i) == fill_ff) ? entry_type'({q_cmd.cls, q_cmd.tid})
                                                      : ent_ff[i];
      end
      if (i == GROUP_DEPTH - 1) begin : g_tail
         assign shl[i] = ent_ff[i];
      end else begin : g_mid
         assign shl[i] = ent_ff[i+1];
      end
   end

   assign step      = (state_ff == BK_EMIT) && (!rsp_valid_ff || rsp_if.ready);
   assign do_insert = q_pop && q_cmd.kind == CMD_ID && fill_ff < FW'(GROUP_DEPTH);
   assign close_cmd = q_cmd.kind == CMD_CLOSE || q_cmd.kind == CMD_END;
   assign is_last   = (fill_ff == FW'(1));
   assign cls_start = first_ff || (prev_cls_ff != ent_ff[0].cls);
   assign cls_end   = is_last || (ent_ff[1].cls != ent_ff[0].cls);
   assign sets_inc  = (cls_start && sets_ff < SETS_LIMIT) ? sets_ff + 1'b1 : sets_ff;

   // pop commands only while idle
   always_comb begin
      q_pop = (state_ff == BK_IDLE) && !q_status.empty;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_pop && close_cmd && fill_ff != '0) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (step && is_last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // group counters and flags
   always_comb begin
      fill_in  = fill_ff;
      sets_in  = sets_ff;
      ovf_in   = ovf_ff;
      end_in   = end_ff;
      first_in = first_ff;
      if (q_pop) begin
         case (q_cmd.kind)
            CMD_ID: begin
               if (do_insert) begin
                  fill_in = fill_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            CMD_CLOSE, CMD_END: begin
               end_in   = (q_cmd.kind == CMD_END);
               first_in = 1'b1;
               if (fill_ff == '0) begin
                  ovf_in = 1'b0;
                  if (q_cmd.kind == CMD_END) begin
                     sets_in = '0;
                  end
               end
            end
            CMD_CLEAR: begin
               fill_in = '0;
               sets_in = '0;
               ovf_in  = 1'b0;
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
      if (step) begin
         fill_in  = fill_ff - 1'b1;
         sets_in  = sets_inc;
         first_in = 1'b0;
         if (is_last) begin
            ovf_in = 1'b0;
            if (end_ff) begin
               sets_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_ff      <= '0;
         sets_ff      <= '0;
         ovf_ff       <= 1'b0;
         end_ff       <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         sets_ff  <= sets_in;
         ovf_ff   <= ovf_in;
         end_ff   <= end_in;
         first_ff <= first_in;
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // buffer entries and result payload
   always_ff @(posedge clock) begin
      if (do_insert) begin
         ent_ff <= ins;
      end else if (step) begin
         ent_ff <= shl;
      end
      if (step) begin
         prev_cls_ff <= ent_ff[0].cls;
         rsp_tid_ff  <= ent_ff[0].tid;
         rsp_end_ff  <= cls_end;
         rsp_last_ff <= is_last;
         rsp_sets_ff <= sets_inc;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_tid   = rsp_tid_ff;
   assign rsp_if.class_end = rsp_end_ff;
   assign rsp_if.last      = rsp_last_ff;
   assign rsp_if.set_count = rsp_sets_ff;
   assign rsp_if.overflow  = rsp_ovf_ff;

endmodule
